/* src/manhattan_threshold_reachability_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the Manhattan threshold reachability unit
// Concurrent checks on clk_i, disabled while rst_ni is low; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef MANHATTAN_THRESHOLD_REACHABILITY_UNIT_ASSERT_SVH
`define MANHATTAN_THRESHOLD_REACHABILITY_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// expression must never hold at a clock edge out of reset
`define MTR_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
// consequent must hold in the cycle after the antecedent
`define MTR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);
`else
`define MTR_ASSERT_NEVER(lbl, expr, msg)
`define MTR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* src/mtr_pkg.sv */
// ----------------------------------------------------------------------------
// mtr_pkg
// Shared types, constants and helpers of the reachability unit.
// ----------------------------------------------------------------------------
package mtr_pkg;

  localparam int unsigned COORD_W     = 16;
  localparam int unsigned STEP_W      = 17;
  localparam logic [STEP_W-1:0] STEP_RESET = 17'd1000;
  localparam int unsigned QUEUE_DEPTH = 4;

  // one stored point as it travels from front to back
  typedef struct packed {
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
    logic                      last;
    logic                      ovf;
  } mtr_point_t;

  // coordinates as kept in the point memory
  typedef struct packed {
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } mtr_coord_t;

  // back-end walk sequencer
  typedef enum logic [2:0] {
    BK_LOAD,
    BK_INIT,
    BK_POP,
    BK_CUR,
    BK_CURLAT,
    BK_SWEEP,
    BK_DONE
  } mtr_back_state_e;

  // |a - b| of two signed coordinates; always fits in COORD_W bits
  function automatic logic [COORD_W-1:0] abs_diff(logic signed [COORD_W-1:0] a,
                                                  logic signed [COORD_W-1:0] b);
    logic [COORD_W:0] d;
    logic [COORD_W:0] n;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    n = ~d + {{COORD_W{1'b0}}, 1'b1};
    return d[COORD_W] ? n[COORD_W-1:0] : d[COORD_W-1:0];
  endfunction

endpackage

/* src/mtr_front.sv */
// ----------------------------------------------------------------------------
// mtr_front
// Accepts points, assigns store slots, tracks the set count and overflow.
// ----------------------------------------------------------------------------
module mtr_front import mtr_pkg::*; #(
  parameter int unsigned MAX_POINTS = 128
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [COORD_W-1:0] coord_y_i,
  input  logic signed [COORD_W-1:0] coord_x_i,
  input  logic                      last_point_i,
  input  logic                      q_full_i,
  output logic                      push_o,
  output logic [$clog2(MAX_POINTS)-1:0] slot_o,
  output mtr_point_t                point_o
);

  localparam int unsigned IDX_W = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);

  logic [CNT_W-1:0] count_d, count_q;
  logic             ovf_d, ovf_q;
  logic             accept;
  logic             has_room;

  // classify the incoming point
  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign has_room   = count_q < CNT_W'(MAX_POINTS);

  // dropped points are not queued; a last point always is
  assign push_o  = accept && (has_room || last_point_i);
  assign slot_o  = has_room ? count_q[IDX_W-1:0] : IDX_W'(MAX_POINTS - 1);
  assign point_o = '{y: coord_y_i, x: coord_x_i, last: last_point_i,
                     ovf: ovf_q || !has_room};

  // set bookkeeping
  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    if (accept) begin
      if (last_point_i) begin
        count_d = '0;
        ovf_d   = 1'b0;
      end else if (has_room) begin
        count_d = count_q + CNT_W'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

/* src/mtr_fifo.sv */
// ----------------------------------------------------------------------------
// mtr_fifo
// Short queue between the front and back ends.
// ----------------------------------------------------------------------------
module mtr_fifo import mtr_pkg::*; #(
  parameter int unsigned DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output logic [DATA_W-1:0] rdata_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned LVL_W = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_W-1:0] mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_d, wr_ptr_q;
  logic [PTR_W-1:0]  rd_ptr_d, rd_ptr_q;
  logic [LVL_W-1:0]  level_d, level_q;

  assign full_o  = level_q == LVL_W'(QUEUE_DEPTH);
  assign valid_o = level_q != '0;
  assign rdata_o = mem_q[rd_ptr_q];

  // pointer and fill level update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    level_d  = level_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      level_d = level_q + LVL_W'(1);
    end else if (pop_i && !push_i) begin
      level_d = level_q - LVL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

/* src/mtr_back.sv */
// ----------------------------------------------------------------------------
// mtr_back
// Stores points and walks the link graph from the first to the last point.
// ----------------------------------------------------------------------------
module mtr_back import mtr_pkg::*; #(
  parameter int unsigned MAX_POINTS = 128
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [STEP_W-1:0]             max_step_i,
  input  logic                          q_valid_i,
  input  logic [$clog2(MAX_POINTS)-1:0] q_slot_i,
  input  mtr_point_t                    q_point_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          reachable_o,
  output logic                          overflow_o
);

  localparam int unsigned IDX_W = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);

  mtr_back_state_e state_d, state_q;

  // memories
  mtr_coord_t       pmem_q [MAX_POINTS];
  mtr_coord_t       pmem_rd_q;
  logic [IDX_W-1:0] pmem_raddr;
  logic             pmem_we;
  logic [IDX_W-1:0] wl_q [MAX_POINTS];
  logic [IDX_W-1:0] wl_rd_q;
  logic             wl_we;
  logic [IDX_W-1:0] wl_waddr;
  logic [IDX_W-1:0] wl_wdata;

  // walk state
  logic [MAX_POINTS-1:0]    reached_q;
  logic [IDX_W-1:0]         dest_q;
  logic                     ovf_q;
  logic [CNT_W-1:0]         head_q, tail_q;
  logic signed [COORD_W-1:0] cur_y_q, cur_x_q;
  logic                     run_q;
  logic [IDX_W-1:0]         sweep_i_q;
  logic                     s1_valid_q;
  logic [IDX_W-1:0]         s1_idx_q;
  logic                     s2_valid_q;
  logic [IDX_W-1:0]         s2_idx_q;
  logic [COORD_W-1:0]       dy_q, dx_q;
  logic                     out_valid_q, reachable_q, overflow_q;

  // control strobes
  logic             wl_empty;
  logic             dest_hit;
  logic             sweep_idle;
  logic             issue;
  logic [STEP_W-1:0] link_dist;
  logic             mark;
  logic             res_load;

  assign wl_empty   = head_q == tail_q;
  assign dest_hit   = reached_q[dest_q];
  assign sweep_idle = !run_q && !s1_valid_q && !s2_valid_q;
  assign issue      = (state_q == BK_SWEEP) && run_q;
  assign link_dist  = {1'b0, dy_q} + {1'b0, dx_q};
  assign mark       = s2_valid_q && (link_dist <= max_step_i) && !reached_q[s2_idx_q];
  assign res_load   = (state_q == BK_DONE) && (!out_valid_q || out_ready_i);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_LOAD:   if (q_valid_i && q_point_i.last) state_d = BK_INIT;
      BK_INIT:   state_d = BK_POP;
      BK_POP:    state_d = (wl_empty || dest_hit) ? BK_DONE : BK_CUR;
      BK_CUR:    state_d = BK_CURLAT;
      BK_CURLAT: state_d = BK_SWEEP;
      BK_SWEEP:  if (sweep_idle) state_d = BK_POP;
      BK_DONE:   if (res_load) state_d = BK_LOAD;
      default:   state_d = BK_LOAD;
    endcase
  end

  // memory port control
  always_comb begin
    q_pop_o    = 1'b0;
    pmem_we    = 1'b0;
    pmem_raddr = sweep_i_q;
    wl_we      = 1'b0;
    wl_waddr   = tail_q[IDX_W-1:0];
    wl_wdata   = s2_idx_q;
    unique case (state_q)
      BK_LOAD: begin
        q_pop_o = q_valid_i;
        pmem_we = q_valid_i;
      end
      BK_INIT: begin
        wl_we    = 1'b1;
        wl_waddr = '0;
        wl_wdata = '0;
      end
      BK_CUR: begin
        pmem_raddr = wl_rd_q;
      end
      BK_SWEEP: begin
        wl_we = mark;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // point memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (pmem_we) begin
      pmem_q[q_slot_i] <= '{y: q_point_i.y, x: q_point_i.x};
    end
    pmem_rd_q <= pmem_q[pmem_raddr];
  end

  // work list memory: write at tail, read at head
  always_ff @(posedge clk_i) begin
    if (wl_we) begin
      wl_q[wl_waddr] <= wl_wdata;
    end
    wl_rd_q <= wl_q[head_q[IDX_W-1:0]];
  end

  // walk control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reached_q  <= '0;
      head_q     <= '0;
      tail_q     <= '0;
      run_q      <= 1'b0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= issue;
      s2_valid_q <= s1_valid_q;
      if (state_q == BK_INIT) begin
        // only the first point starts out reached
        reached_q <= MAX_POINTS'(1);
        head_q    <= '0;
        tail_q    <= CNT_W'(1);
      end
      if (state_q == BK_POP && !wl_empty && !dest_hit) begin
        head_q <= head_q + CNT_W'(1);
      end
      if (state_q == BK_CURLAT) begin
        run_q <= 1'b1;
      end else if (issue && sweep_i_q == dest_q) begin
        run_q <= 1'b0;
      end
      if (mark) begin
        reached_q[s2_idx_q] <= 1'b1;
        tail_q              <= tail_q + CNT_W'(1);
      end
    end
  end

  // walk datapath
  always_ff @(posedge clk_i) begin
    if (state_q == BK_LOAD && q_valid_i && q_point_i.last) begin
      dest_q <= q_slot_i;
      ovf_q  <= q_point_i.ovf;
    end
    if (state_q == BK_CURLAT) begin
      cur_y_q   <= pmem_rd_q.y;
      cur_x_q   <= pmem_rd_q.x;
      sweep_i_q <= '0;
    end else if (issue) begin
      sweep_i_q <= sweep_i_q + IDX_W'(1);
    end
    s1_idx_q <= sweep_i_q;
    // distance terms registered before the sum and compare
    s2_idx_q <= s1_idx_q;
    dy_q     <= abs_diff(pmem_rd_q.y, cur_y_q);
    dx_q     <= abs_diff(pmem_rd_q.x, cur_x_q);
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      reachable_q <= dest_hit;
      overflow_q  <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign reachable_o = reachable_q;
  assign overflow_o  = overflow_q;

endmodule

/* src/manhattan_threshold_reachability_unit.sv */
// Points load at one item per cycle while the queue has room (queue depth 4).
// After the last item the walk sweeps all stored points for each expanded point,
// through the point memory's single read port.
// The result register frees the input.
// Reset clears the set count, overflow flag, walk state and max_step to 1000.
// ----------------------------------------------------------------------------
// manhattan_threshold_reachability_unit
// Decides whether the last point of a set is reachable over short links.
// ----------------------------------------------------------------------------
`include "manhattan_threshold_reachability_unit_assert.svh"

module manhattan_threshold_reachability_unit import mtr_pkg::*; #(
  parameter int unsigned MAX_POINTS = 128
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      max_step_we_i,
  input  logic [STEP_W-1:0]         max_step_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [COORD_W-1:0] coord_y_i,
  input  logic signed [COORD_W-1:0] coord_x_i,
  input  logic                      last_point_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      reachable_o,
  output logic                      overflow_o
);

  localparam int unsigned IDX_W  = $clog2(MAX_POINTS);
  localparam int unsigned DATA_W = IDX_W + $bits(mtr_point_t);

  logic [STEP_W-1:0] max_step_q;
  logic              q_push, q_full, q_pop, q_valid;
  logic [IDX_W-1:0]  f_slot, b_slot;
  mtr_point_t        f_point, b_point;
  logic [DATA_W-1:0] q_rdata;

  // step limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_step_q <= STEP_RESET;
    end else if (max_step_we_i) begin
      max_step_q <= max_step_i;
    end
  end

  mtr_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .coord_y_i    (coord_y_i),
    .coord_x_i    (coord_x_i),
    .last_point_i (last_point_i),
    .q_full_i     (q_full),
    .push_o       (q_push),
    .slot_o       (f_slot),
    .point_o      (f_point)
  );

  mtr_fifo #(.DATA_W(DATA_W)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i ({f_slot, f_point}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  assign {b_slot, b_point} = q_rdata;

  mtr_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .max_step_i  (max_step_q),
    .q_valid_i   (q_valid),
    .q_slot_i    (b_slot),
    .q_point_i   (b_point),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .reachable_o (reachable_o),
    .overflow_o  (overflow_o)
  );

  // queue discipline between front and back
  `MTR_ASSERT_NEVER(a_no_push_full, q_push && q_full, "point queued while queue full")
  `MTR_ASSERT_NEVER(a_no_pop_empty, q_pop && !q_valid, "point taken from empty queue")
  `MTR_ASSERT_NEXT(a_push_visible, q_push && !q_pop, q_valid, "queued point not visible")

endmodule
